FILE: src/afr_pkg.sv
// ----------------------------------------------------------------------------
// afr_pkg
// shared codes and field widths of the addressed frame receiver
// ----------------------------------------------------------------------------
package afr_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned FLAG_W  = 2;
  localparam int unsigned CFG_W   = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_RECV    = 2'd0,
    FUNC_READ    = 2'd1,
    FUNC_RELEASE = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [FLAG_W-1:0] {
    FLAG_NONE = 2'd0,
    FLAG_HELD = 2'd1,
    FLAG_BUSY = 2'd2,
    FLAG_RSVD = 2'd3
  } flag_t;

  typedef enum logic [CFG_W-1:0] {
    REG_SYNC_BYTE   = 2'd0,
    REG_DEVICE_ADDR = 2'd1,
    REG_END_FIRST   = 2'd2,
    REG_END_SECOND  = 2'd3
  } reg_index_t;

endpackage

FILE: src/afr_cfg_if.sv
// ----------------------------------------------------------------------------
// afr_cfg_if
// configuration write channel: register index and data
// ----------------------------------------------------------------------------
interface afr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [afr_pkg::CFG_W-1:0]       index;
  logic [afr_pkg::BYTE_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/afr_req_if.sv
// ----------------------------------------------------------------------------
// afr_req_if
// request channel: receive, read or release transaction
// ----------------------------------------------------------------------------
interface afr_req_if;
  logic                            valid;
  logic                            ready;
  logic [afr_pkg::FUNC_W-1:0]      func;
  logic [afr_pkg::BYTE_W-1:0]      data_byte;
  logic [afr_pkg::INDEX_W-1:0]     read_index;

  modport source (output valid, output func, output data_byte, output read_index,
                  input ready);
  modport sink (input valid, input func, input data_byte, input read_index,
                output ready);
endinterface

FILE: src/afr_rsp_if.sv
// ----------------------------------------------------------------------------
// afr_rsp_if
// result channel: frame status, read byte and stored count
// ----------------------------------------------------------------------------
interface afr_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [afr_pkg::FLAG_W-1:0]      frame_status;
  logic [afr_pkg::BYTE_W-1:0]      read_byte;
  logic [afr_pkg::COUNT_W-1:0]     stored_count;

  modport source (output valid, output frame_status, output read_byte,
                  output stored_count, input ready);
  modport sink (input valid, input frame_status, input read_byte,
                input stored_count, output ready);
endinterface

FILE: src/afr_ram.sv
// ----------------------------------------------------------------------------
// afr_ram
// generic simple dual port ram, one write port, registered read port
// ----------------------------------------------------------------------------
module afr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 35
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/addressed_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// addressed_frame_receiver_unit
// parses addressed serial frames into a byte store and answers reads
// ----------------------------------------------------------------------------
// channels: cfg writes one of four registers (sync, device address, two
// terminator bytes); it is always ready. req carries one transaction per
// item: receive a byte, read a stored byte, or release a held frame. rsp
// returns one result per request: frame status, read byte, stored count.
// timing: a request's result is offered on rsp in the cycle after it is
// taken. throughput: one request per cycle while rsp is not stalled; the
// parser state update is one combinational step and the byte store is a
// ram with one write and one registered read port; only receives write
// it, only reads use its data. the read data sits in the ram output register,
// which only loads when a request is taken, so it holds while rsp is stalled.
// stall: rsp has a single output register; req.ready follows rsp.ready when
// that register is full, so a stalled receiver stalls requests in place.
// reset: parser waits for sync, no frame, count zero, registers to defaults.
// the store itself is not cleared; only bytes of the current frame are read.
// ----------------------------------------------------------------------------
module addressed_frame_receiver_unit #(
  parameter int unsigned MAX_DATA = 32
) (
  input  logic         clk,
  input  logic         rst,
  afr_cfg_if.sink      cfg,
  afr_req_if.sink      req,
  afr_rsp_if.source    rsp
);

  localparam int unsigned STORE_DEPTH = MAX_DATA + 3;
  localparam int unsigned AW          = $clog2(STORE_DEPTH);
  localparam int unsigned DL_W        = $clog2(MAX_DATA);
  localparam logic [afr_pkg::COUNT_W-1:0] DEPTH_C = afr_pkg::COUNT_W'(STORE_DEPTH);
  localparam logic [afr_pkg::BYTE_W-1:0]  MAX_C   = afr_pkg::BYTE_W'(MAX_DATA);

  typedef enum logic [2:0] {
    ST_SYNC = 3'd0,
    ST_ADDR = 3'd1,
    ST_CMND = 3'd2,
    ST_LEN  = 3'd3,
    ST_DATA = 3'd4,
    ST_CHS  = 3'd5,
    ST_END0 = 3'd6,
    ST_END1 = 3'd7
  } parse_t;

  // configuration registers
  logic [afr_pkg::BYTE_W-1:0] sync_byte;
  logic [afr_pkg::BYTE_W-1:0] device_address;
  logic [afr_pkg::BYTE_W-1:0] end_byte_first;
  logic [afr_pkg::BYTE_W-1:0] end_byte_second;

  // parser state
  parse_t                      parse_state, parse_state_next;
  afr_pkg::flag_t              frame_flag, frame_flag_next;
  logic [afr_pkg::BYTE_W-1:0]  running_xor, running_xor_next;
  logic [DL_W-1:0]             data_left, data_left_next, data_left_dec;
  logic [afr_pkg::COUNT_W-1:0] write_count, write_count_next, write_base;

  // result register
  logic                        out_valid;
  afr_pkg::flag_t              status_q;
  logic [afr_pkg::COUNT_W-1:0] count_q;
  logic                        hit_q;

  logic                        req_fire;
  logic                        store_en;
  logic                        read_hit;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [afr_pkg::BYTE_W-1:0]  ram_rdata;
  afr_pkg::func_t              func;
  logic [afr_pkg::BYTE_W-1:0]  c;

  assign cfg.ready = 1'b1;
  assign req.ready = !out_valid || rsp.ready;
  assign req_fire  = req.valid && req.ready;
  assign func      = afr_pkg::func_t'(req.func);
  assign c         = req.data_byte;
  assign data_left_dec = (data_left != '0) ? data_left - 1'b1 : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte       <= 8'd32;
      device_address  <= 8'd0;
      end_byte_first  <= 8'd13;
      end_byte_second <= 8'd10;
    end else if (cfg.valid) begin
      unique case (afr_pkg::reg_index_t'(cfg.index))
        afr_pkg::REG_SYNC_BYTE:   sync_byte       <= cfg.data;
        afr_pkg::REG_DEVICE_ADDR: device_address  <= cfg.data;
        afr_pkg::REG_END_FIRST:   end_byte_first  <= cfg.data;
        afr_pkg::REG_END_SECOND:  end_byte_second <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    parse_state_next = parse_state;
    frame_flag_next  = frame_flag;
    running_xor_next = running_xor;
    data_left_next   = data_left;
    write_count_next = write_count;
    write_base       = write_count;
    store_en         = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = write_count[AW-1:0];
    if (req_fire) begin
      unique case (func)
        afr_pkg::FUNC_RECV: begin
          if (frame_flag != afr_pkg::FLAG_HELD) begin
            unique case (parse_state)
              ST_SYNC: begin
                if (c == sync_byte) parse_state_next = ST_ADDR;
              end
              ST_ADDR: begin
                if (c == device_address) begin
                  write_base       = '0;
                  store_en         = 1'b1;
                  parse_state_next = ST_CMND;
                end else begin
                  parse_state_next = ST_SYNC;
                end
              end
              ST_CMND: begin
                running_xor_next = c;
                store_en         = 1'b1;
                parse_state_next = ST_LEN;
                frame_flag_next  = afr_pkg::FLAG_BUSY;
              end
              ST_LEN: begin
                running_xor_next = running_xor ^ c;
                data_left_next   = c[DL_W-1:0];
                store_en         = 1'b1;
                if (c == '0) begin
                  parse_state_next = ST_CHS;
                end else if (c < MAX_C) begin
                  parse_state_next = ST_DATA;
                end else begin
                  parse_state_next = ST_SYNC;
                  frame_flag_next  = afr_pkg::FLAG_NONE;
                end
              end
              ST_DATA: begin
                running_xor_next = running_xor ^ c;
                store_en         = 1'b1;
                data_left_next   = data_left_dec;
                if (data_left_dec == '0) parse_state_next = ST_CHS;
              end
              ST_CHS: begin
                store_en         = 1'b1;
                parse_state_next = (c == running_xor) ? ST_END0 : ST_SYNC;
              end
              ST_END0: begin
                parse_state_next = (c == end_byte_first) ? ST_END1 : ST_SYNC;
              end
              ST_END1: begin
                frame_flag_next  = (c == end_byte_second) ? afr_pkg::FLAG_HELD
                                                          : afr_pkg::FLAG_NONE;
                parse_state_next = ST_SYNC;
              end
              default: parse_state_next = ST_SYNC;
            endcase
          end
        end
        afr_pkg::FUNC_RELEASE: begin
          if (frame_flag == afr_pkg::FLAG_HELD) frame_flag_next = afr_pkg::FLAG_NONE;
        end
        default: ;
      endcase
    end
    if (store_en) begin
      write_count_next = write_base;
      if (write_base < DEPTH_C) begin
        ram_we           = 1'b1;
        ram_waddr        = write_base[AW-1:0];
        write_count_next = write_base + 1'b1;
      end
    end
  end

  // a read never shares a cycle with a write, so no forwarding is needed
  assign read_hit = (func == afr_pkg::FUNC_READ) &&
                    ({{(afr_pkg::COUNT_W-afr_pkg::INDEX_W){1'b0}}, req.read_index}
                     < write_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state <= ST_SYNC;
      frame_flag  <= afr_pkg::FLAG_NONE;
      running_xor <= '0;
      data_left   <= '0;
      write_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      parse_state <= parse_state_next;
      frame_flag  <= frame_flag_next;
      running_xor <= running_xor_next;
      data_left   <= data_left_next;
      write_count <= write_count_next;
      if (req_fire) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      status_q <= frame_flag_next;
      count_q  <= write_count_next;
      hit_q    <= read_hit;
    end
  end

  afr_ram #(
    .WIDTH (afr_pkg::BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (c),
    .rd_en   (req_fire),
    .rd_addr (req.read_index[AW-1:0]),
    .rd_data (ram_rdata)
  );

  assign rsp.valid        = out_valid;
  assign rsp.frame_status = status_q;
  assign rsp.stored_count = count_q;
  assign rsp.read_byte    = hit_q ? ram_rdata : '0;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    write_count <= DEPTH_C)
    else $error("stored count beyond store depth");

  a_held_frozen: assert property (@(posedge clk) disable iff (rst)
    req_fire && func == afr_pkg::FUNC_RECV && frame_flag == afr_pkg::FLAG_HELD
    |=> $stable(write_count) && $stable(parse_state) && frame_flag == afr_pkg::FLAG_HELD)
    else $error("held frame changed by a received byte");

  a_release: assert property (@(posedge clk) disable iff (rst)
    req_fire && func == afr_pkg::FUNC_RELEASE |=> frame_flag != afr_pkg::FLAG_HELD)
    else $error("frame still held after release");

  a_result_status: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> out_valid && status_q == frame_flag && count_q == write_count)
    else $error("result does not match updated state");
`endif

endmodule

FILE: tb/addressed_frame_receiver_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// addressed_frame_receiver_unit_tb
// self-checking bench for the addressed frame receiver: streams framed and
// broken byte sequences, reads and releases through the request channel under
// several register settings and idling patterns, predicts every result with
// its own frame parser and compares status, read byte and count per result
// ----------------------------------------------------------------------------
module addressed_frame_receiver_unit_tb;

  localparam int MAX_DATA         = 32;
  localparam int STORE_DEPTH      = MAX_DATA + 3;
  localparam int RANDOM_PER_PHASE = 250;
  localparam int NUM_PHASES       = 6;

  typedef enum logic [2:0] {
    PS_SYNC, PS_ADDR, PS_CMND, PS_LEN, PS_DATA, PS_CHS, PS_END0, PS_END1
  } parse_state_t;

  typedef enum int {
    FAULT_NONE, FAULT_ADDR, FAULT_CHK, FAULT_END0, FAULT_END1, FAULT_LEN
  } fault_t;

  typedef struct packed {
    afr_pkg::func_t              func;
    logic [afr_pkg::BYTE_W-1:0]  data_byte;
    logic [afr_pkg::INDEX_W-1:0] read_index;
  } request_t;

  typedef struct packed {
    afr_pkg::flag_t              frame_status;
    logic [afr_pkg::BYTE_W-1:0]  read_byte;
    logic [afr_pkg::COUNT_W-1:0] stored_count;
  } frame_result_t;

  logic clk;
  logic rst;

  afr_cfg_if cfg ();
  afr_req_if req ();
  afr_rsp_if rsp ();

  addressed_frame_receiver_unit #(.MAX_DATA(MAX_DATA)) dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (req),
    .rsp (rsp)
  );

  // parser copy
  logic [afr_pkg::BYTE_W-1:0]  sync_reg;
  logic [afr_pkg::BYTE_W-1:0]  addr_reg;
  logic [afr_pkg::BYTE_W-1:0]  end_first_reg;
  logic [afr_pkg::BYTE_W-1:0]  end_second_reg;
  parse_state_t                parse_st;
  afr_pkg::flag_t              frame_flag;
  logic [afr_pkg::BYTE_W-1:0]  check_xor;
  logic [afr_pkg::BYTE_W-1:0]  bytes_left;
  logic [afr_pkg::COUNT_W-1:0] write_count;
  logic [afr_pkg::BYTE_W-1:0]  frame_store [STORE_DEPTH];

  // values the stimulus builds frames with
  logic [afr_pkg::BYTE_W-1:0]  tx_sync;
  logic [afr_pkg::BYTE_W-1:0]  tx_addr;
  logic [afr_pkg::BYTE_W-1:0]  tx_end_first;
  logic [afr_pkg::BYTE_W-1:0]  tx_end_second;

  request_t      pending_requests [$];
  frame_result_t frame_results_q [$];
  request_t      drv_item;
  frame_result_t oldest_result;
  logic          req_taken;
  int            requests_queued;
  int            results_matched;
  int            error_count;
  int            send_idle_pct;
  int            rx_stall_pct;

  function automatic void store_byte(logic [afr_pkg::BYTE_W-1:0] b);
    if (write_count < STORE_DEPTH) begin
      frame_store[write_count] = b;
      write_count++;
    end
  endfunction

  function automatic frame_result_t parse_request(request_t r);
    frame_result_t              res;
    logic [afr_pkg::BYTE_W-1:0] c;
    c = r.data_byte;
    res.read_byte = '0;
    case (r.func)
      afr_pkg::FUNC_RECV: begin
        if (frame_flag != afr_pkg::FLAG_HELD) begin
          case (parse_st)
            PS_SYNC: begin
              if (c == sync_reg) parse_st = PS_ADDR;
            end
            PS_ADDR: begin
              if (c == addr_reg) begin
                write_count = '0;
                store_byte(c);
                parse_st = PS_CMND;
              end else begin
                parse_st = PS_SYNC;
              end
            end
            PS_CMND: begin
              check_xor = c;
              store_byte(c);
              parse_st = PS_LEN;
              frame_flag = afr_pkg::FLAG_BUSY;
            end
            PS_LEN: begin
              check_xor ^= c;
              bytes_left = c;
              store_byte(c);
              if (c == 0) begin
                parse_st = PS_CHS;
              end else if (c < MAX_DATA) begin
                parse_st = PS_DATA;
              end else begin
                parse_st = PS_SYNC;
                frame_flag = afr_pkg::FLAG_NONE;
              end
            end
            PS_DATA: begin
              check_xor ^= c;
              store_byte(c);
              if (bytes_left > 0) bytes_left--;
              if (bytes_left == 0) parse_st = PS_CHS;
            end
            PS_CHS: begin
              store_byte(c);
              parse_st = (c == check_xor) ? PS_END0 : PS_SYNC;
            end
            PS_END0: begin
              parse_st = (c == end_first_reg) ? PS_END1 : PS_SYNC;
            end
            default: begin
              frame_flag = (c == end_second_reg) ? afr_pkg::FLAG_HELD : afr_pkg::FLAG_NONE;
              parse_st = PS_SYNC;
            end
          endcase
        end
      end
      afr_pkg::FUNC_READ: begin
        if (r.read_index < write_count && r.read_index < STORE_DEPTH)
          res.read_byte = frame_store[r.read_index];
      end
      afr_pkg::FUNC_RELEASE: begin
        if (frame_flag == afr_pkg::FLAG_HELD) frame_flag = afr_pkg::FLAG_NONE;
      end
      default: ;
    endcase
    res.frame_status = frame_flag;
    res.stored_count = write_count;
    return res;
  endfunction

  // unused fields of a transaction carry random values
  function automatic void add_request(afr_pkg::func_t f, logic [afr_pkg::BYTE_W-1:0] b,
                                      logic [afr_pkg::INDEX_W-1:0] idx);
    request_t r;
    r.func       = f;
    r.data_byte  = (f == afr_pkg::FUNC_RECV) ? b : afr_pkg::BYTE_W'($urandom);
    r.read_index = (f == afr_pkg::FUNC_READ) ? idx : afr_pkg::INDEX_W'($urandom);
    pending_requests.push_back(r);
    requests_queued++;
  endfunction

  function automatic void send_byte(logic [afr_pkg::BYTE_W-1:0] b);
    add_request(afr_pkg::FUNC_RECV, b, '0);
  endfunction

  function automatic logic [afr_pkg::BYTE_W-1:0] corrupt(logic [afr_pkg::BYTE_W-1:0] v);
    return v ^ afr_pkg::BYTE_W'($urandom_range(255, 1));
  endfunction

  function automatic void add_frame(fault_t fault, int len);
    logic [afr_pkg::BYTE_W-1:0] cmd;
    logic [afr_pkg::BYTE_W-1:0] chk;
    logic [afr_pkg::BYTE_W-1:0] b;
    cmd = afr_pkg::BYTE_W'($urandom);
    chk = cmd ^ afr_pkg::BYTE_W'(len);
    send_byte(tx_sync);
    send_byte((fault == FAULT_ADDR) ? corrupt(tx_addr) : tx_addr);
    send_byte(cmd);
    send_byte(afr_pkg::BYTE_W'(len));
    if (len < MAX_DATA) begin
      for (int i = 0; i < len; i++) begin
        b = afr_pkg::BYTE_W'($urandom);
        chk ^= b;
        send_byte(b);
      end
    end
    send_byte((fault == FAULT_CHK) ? corrupt(chk) : chk);
    send_byte((fault == FAULT_END0) ? corrupt(tx_end_first) : tx_end_first);
    send_byte((fault == FAULT_END1) ? corrupt(tx_end_second) : tx_end_second);
  endfunction

  function automatic void add_random_traffic(int target);
    int     first;
    int     len;
    int     pick;
    int     hi;
    fault_t fault;
    first = requests_queued;
    while (requests_queued - first < target) begin
      if ($urandom_range(99) < 75) begin
        pick = $urandom_range(99);
        if (pick < 62) fault = FAULT_NONE;
        else if (pick < 69) fault = FAULT_ADDR;
        else if (pick < 76) fault = FAULT_CHK;
        else if (pick < 83) fault = FAULT_END0;
        else if (pick < 90) fault = FAULT_END1;
        else fault = FAULT_LEN;
        if (fault == FAULT_LEN) len = $urandom_range(255, MAX_DATA);
        else if ($urandom_range(9) < 8) len = $urandom_range(6);
        else len = $urandom_range(MAX_DATA - 1);
        add_frame(fault, len);
        hi = (len + 6 > 63) ? 63 : len + 6;
        repeat ($urandom_range(4, 1))
          add_request(afr_pkg::FUNC_READ, '0,
                      ($urandom_range(4) == 0) ? afr_pkg::INDEX_W'($urandom_range(63))
                                               : afr_pkg::INDEX_W'($urandom_range(hi)));
        if ($urandom_range(9) == 0) send_byte(afr_pkg::BYTE_W'($urandom));
        if ($urandom_range(9) < 8) add_request(afr_pkg::FUNC_RELEASE, '0, '0);
      end else begin
        repeat ($urandom_range(4, 1))
          add_request(afr_pkg::func_t'($urandom_range(3)), afr_pkg::BYTE_W'($urandom),
                      afr_pkg::INDEX_W'($urandom));
      end
    end
  endfunction

  task automatic write_reg(afr_pkg::reg_index_t idx, logic [afr_pkg::BYTE_W-1:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic set_config(logic [afr_pkg::BYTE_W-1:0] s, logic [afr_pkg::BYTE_W-1:0] a,
                            logic [afr_pkg::BYTE_W-1:0] e0,
                            logic [afr_pkg::BYTE_W-1:0] e1);
    write_reg(afr_pkg::REG_SYNC_BYTE, s);
    write_reg(afr_pkg::REG_DEVICE_ADDR, a);
    write_reg(afr_pkg::REG_END_FIRST, e0);
    write_reg(afr_pkg::REG_END_SECOND, e1);
    tx_sync       = s;
    tx_addr       = a;
    tx_end_first  = e0;
    tx_end_second = e1;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (results_matched != requests_queued);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // request driver
  always @(negedge clk) begin
    if (!req.valid || req_taken) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_item = pending_requests.pop_front();
        req.valid      <= 1'b1;
        req.func       <= drv_item.func;
        req.data_byte  <= drv_item.data_byte;
        req.read_index <= drv_item.read_index;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(negedge clk) begin
    rsp.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // monitor and prediction
  always @(posedge clk) begin
    if (rst) begin
      sync_reg       = 8'd32;
      addr_reg       = 8'd0;
      end_first_reg  = 8'd13;
      end_second_reg = 8'd10;
      parse_st       = PS_SYNC;
      frame_flag     = afr_pkg::FLAG_NONE;
      check_xor      = '0;
      bytes_left     = '0;
      write_count    = '0;
      req_taken     <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (frame_results_q.size() == 0) begin
          $error("unexpected result: frame_status %0d read_byte %0d stored_count %0d",
                 rsp.frame_status, rsp.read_byte, rsp.stored_count);
          error_count++;
        end else begin
          oldest_result = frame_results_q.pop_front();
          if (rsp.frame_status !== oldest_result.frame_status) begin
            $error("frame_status: expected %0d, actual %0d",
                   oldest_result.frame_status, rsp.frame_status);
            error_count++;
          end
          if (rsp.read_byte !== oldest_result.read_byte) begin
            $error("read_byte: expected %0d, actual %0d",
                   oldest_result.read_byte, rsp.read_byte);
            error_count++;
          end
          if (rsp.stored_count !== oldest_result.stored_count) begin
            $error("stored_count: expected %0d, actual %0d",
                   oldest_result.stored_count, rsp.stored_count);
            error_count++;
          end
          results_matched++;
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (afr_pkg::reg_index_t'(cfg.index))
          afr_pkg::REG_SYNC_BYTE:   sync_reg = cfg.data;
          afr_pkg::REG_DEVICE_ADDR: addr_reg = cfg.data;
          afr_pkg::REG_END_FIRST:   end_first_reg = cfg.data;
          afr_pkg::REG_END_SECOND:  end_second_reg = cfg.data;
          default: ;
        endcase
      end
      req_taken <= req.valid && req.ready;
      if (req.valid && req.ready)
        frame_results_q.push_back(parse_request(
          request_t'{afr_pkg::func_t'(req.func), req.data_byte, req.read_index}));
    end
  end

  initial begin
    rst            = 1'b1;
    cfg.valid      = 1'b0;
    cfg.index      = '0;
    cfg.data       = '0;
    req.valid      = 1'b0;
    req.func       = afr_pkg::FUNC_RECV;
    req.data_byte  = '0;
    req.read_index = '0;
    rsp.ready      = 1'b0;
    send_idle_pct  = 0;
    rx_stall_pct   = 0;
    tx_sync        = 8'd32;
    tx_addr        = 8'd0;
    tx_end_first   = 8'd13;
    tx_end_second  = 8'd10;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // unused code, release with nothing held
    add_request(afr_pkg::FUNC_NONE, 8'hFF, 6'h3F);
    add_request(afr_pkg::FUNC_RELEASE, '0, '0);
    // wrong address
    send_byte(tx_sync);
    send_byte(8'hFF);
    // zero length with bad checksum
    send_byte(tx_sync);
    send_byte(tx_addr);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);
    // oversize length aborts
    send_byte(tx_sync);
    send_byte(tx_addr);
    send_byte(8'h00);
    send_byte(8'hFF);
    // bad first terminator
    send_byte(tx_sync);
    send_byte(tx_addr);
    send_byte(8'h81);
    send_byte(8'h01);
    send_byte(8'h7E);
    send_byte(8'hFE);
    send_byte(8'h00);
    // good zero length frame, then dropped byte, reads and release
    send_byte(tx_sync);
    send_byte(tx_addr);
    send_byte(8'h5A);
    send_byte(8'h00);
    send_byte(8'h5A);
    send_byte(tx_end_first);
    send_byte(tx_end_second);
    send_byte(8'hA5);
    add_request(afr_pkg::FUNC_READ, '0, 6'd0);
    add_request(afr_pkg::FUNC_READ, '0, 6'd3);
    add_request(afr_pkg::FUNC_READ, '0, 6'h3F);
    add_request(afr_pkg::FUNC_RELEASE, '0, '0);
    add_random_traffic(RANDOM_PER_PHASE);
    wait_idle();

    for (int phase = 1; phase < NUM_PHASES; phase++) begin
      case (phase)
        1: set_config(8'h00, 8'h00, 8'h00, 8'h00);
        2: set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        5: set_config(8'd32, 8'd0, 8'd13, 8'd10);
        default: set_config(afr_pkg::BYTE_W'($urandom), afr_pkg::BYTE_W'($urandom),
                            afr_pkg::BYTE_W'($urandom), afr_pkg::BYTE_W'($urandom));
      endcase
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          rx_stall_pct  = 0;
        end
        1: begin
          send_idle_pct = 47;
          rx_stall_pct  = 0;
        end
        2: begin
          send_idle_pct = 0;
          rx_stall_pct  = 47;
        end
        default: begin
          send_idle_pct = 12;
          rx_stall_pct  = 12;
        end
      endcase
      add_random_traffic(RANDOM_PER_PHASE);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (error_count == 0 && frame_results_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: addressed_frame_receiver_unit.f
src/afr_pkg.sv
src/afr_cfg_if.sv
src/afr_req_if.sv
src/afr_rsp_if.sv
src/afr_ram.sv
src/addressed_frame_receiver_unit.sv
tb/addressed_frame_receiver_unit_tb.sv
